@@ design/assert_macros.svh @@
// Assertion helpers, clocked on i_clk, active-low i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define KDHE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define KDHE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ design/kdhe_pkg.sv @@
`default_nettype none
package kdhe_pkg;

    localparam int NUM_CHANNELS_DEF = 64;
    localparam int CHAN_W = 6;
    localparam int CHAN_CNT_W = 9;  // holds channel counts up to 256
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int S_TDATA_W = 40;  // 6 + 1 + 32, byte padded
    localparam int M_TDATA_W = 80;  // 6 + 32 + 32 + 3, byte padded

    localparam logic [1:0] KIND_DOWN = 2'd0;
    localparam logic [1:0] KIND_UP   = 2'd1;
    localparam logic [1:0] KIND_HELD = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HELD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE   = 2'd3;

    localparam logic [15:0] DEBOUNCE_RST = 16'd20;
    localparam logic [15:0] HELD_RST     = 16'd0;
    localparam logic [2:0]  MASK_RST     = 3'd7;
    localparam logic [2:0]  SOURCE_RST   = 3'd0;

    typedef struct packed {
        logic [15:0] deb_ms;
        logic [15:0] held_ms;
        logic [2:0]  kind_mask;
        logic [2:0]  source;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic              raw_down;
        logic [TIME_W-1:0] time_ms;
    } t_sample;

    typedef struct packed {
        logic              stable_lvl;
        logic              last_raw;
        logic [TIME_W-1:0] raw_change_time;
        logic [TIME_W-1:0] press_start;
        logic [TIME_W-1:0] next_held;
    } t_chan_state;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] time_ms;
        logic [TIME_W-1:0] duration;
        logic [2:0]        source;
    } t_event;

endpackage
`default_nettype wire

@@ design/kdhe_chan_store.sv @@
`default_nettype none
module kdhe_chan_store #(
    parameter int NUM_CHANNELS = kdhe_pkg::NUM_CHANNELS_DEF,
    parameter int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_rd_en,
    input  wire logic [AW-1:0]         i_rd_addr,
    input  wire logic                  i_wr_en,
    input  wire logic [AW-1:0]         i_wr_addr,
    input  wire kdhe_pkg::t_chan_state i_wr_data,
    output kdhe_pkg::t_chan_state      o_rd_data,
    output logic                       o_init
);
    import kdhe_pkg::*;

    t_chan_state             r_mem [0:NUM_CHANNELS-1];
    t_chan_state             r_rd;
    t_chan_state             r_byp_data;
    logic                    r_byp;
    logic [NUM_CHANNELS-1:0] r_init;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    // write in flight to the address being read: forward it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
        end else if (i_wr_en) begin
            r_init[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd;
    assign o_init    = r_init[i_wr_addr];

endmodule
`default_nettype wire

@@ design/kdhe_update.sv @@
`default_nettype none
module kdhe_update (
    input  wire kdhe_pkg::t_sample     i_sample,
    input  wire logic                  i_in_range,
    input  wire logic                  i_init,
    input  wire kdhe_pkg::t_chan_state i_state,
    input  wire kdhe_pkg::t_cfg        i_cfg,
    output kdhe_pkg::t_chan_state      o_state,
    output logic                       o_emit,
    output kdhe_pkg::t_event           o_event
);
    import kdhe_pkg::*;

    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] past_held;
    logic [TIME_W-1:0] next_deadline;
    logic              fire;
    logic [1:0]        kind;

    always_comb begin
        since_change  = i_sample.time_ms - i_state.raw_change_time;
        since_press   = i_sample.time_ms - i_state.press_start;
        past_held     = i_sample.time_ms - i_state.next_held;
        next_deadline = i_sample.time_ms + {16'd0, i_cfg.held_ms};

        o_state = i_state;
        fire    = 1'b0;
        kind    = KIND_DOWN;
        o_event.duration = '0;

        if (!i_in_range) begin
            fire = 1'b0;
        end else if (!i_init) begin
            o_state.stable_lvl      = i_sample.raw_down;
            o_state.last_raw        = i_sample.raw_down;
            o_state.raw_change_time = i_sample.time_ms;
            if (i_sample.raw_down) begin
                o_state.press_start = i_sample.time_ms;
                o_state.next_held   = next_deadline;
            end
        end else if (i_state.last_raw != i_sample.raw_down) begin
            o_state.last_raw        = i_sample.raw_down;
            o_state.raw_change_time = i_sample.time_ms;
        end else if (i_state.stable_lvl != i_sample.raw_down) begin
            if (since_change >= {16'd0, i_cfg.deb_ms}) begin
                o_state.stable_lvl = i_sample.raw_down;
                fire = 1'b1;
                if (i_sample.raw_down) begin
                    o_state.press_start = i_sample.time_ms;
                    o_state.next_held   = next_deadline;
                    kind = KIND_DOWN;
                end else begin
                    kind = KIND_UP;
                    o_event.duration = since_press;
                end
            end
        end else if (i_state.stable_lvl && (i_cfg.held_ms != '0) &&
                     !past_held[TIME_W-1]) begin
            o_state.next_held = next_deadline;
            fire = 1'b1;
            kind = KIND_HELD;
            o_event.duration = since_press;
        end

        o_emit          = fire && i_cfg.kind_mask[kind];
        o_event.kind    = kind;
        o_event.channel = i_sample.channel;
        o_event.time_ms = i_sample.time_ms;
        o_event.source  = i_cfg.source;
    end

endmodule
`default_nettype wire

@@ design/key_debounce_held_events_top.sv @@
// Key debouncer with held-key repeat, up to 64 switch channels.
// Slave stream: one raw switch sample per item; the block reports a debounced
// down, up or held event for it on the master stream, or nothing.
// Config channel: writes debounce time, held period, kind mask and source
// handle by register index; write only while no item is in flight.
// An accepted item is registered in the working stage (r_s1), then its event
// in the output register (r_out), from which the master stream takes it.
// Throughput: one item per cycle unless the master stream stalls. Per-channel
// state sits in a one-read, one-write memory read as the item is accepted and
// written back as the item leaves the working stage; a sample on the same
// channel that directly follows gets the forwarded write.
// Reset: config returns to its defaults, all channels become uninitialized
// at once (no clearing pass), the pipeline empties.
// Stall: with the master stream stalled the pending event is held; one more
// item is taken into the working stage, then s_axis tready drops.
`default_nettype none
module key_debounce_held_events_top #(
    parameter int NUM_CHANNELS = kdhe_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // [5:0] channel_index, [6] raw_down, [38:7] sample_time_ms, [39] zero
    input  wire logic [kdhe_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [5:0] event_chan, [37:6] event_time_ms, [69:38] press_duration_ms,
    // [72:70] event_source, [79:73] zero
    output logic [kdhe_pkg::M_TDATA_W-1:0]        o_m_axis_tdata,
    // [1:0] event_kind
    output logic [1:0]                            o_m_axis_tuser,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [kdhe_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [kdhe_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import kdhe_pkg::*;

    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_cfg        r_cfg;
    logic        r_s1_valid;
    t_sample     r_s1;
    logic        r_out_valid;
    t_event      r_out;

    t_sample     in_sample;
    logic        s_accept;
    logic        s1_fire;
    logic        s1_in_range;
    logic        wr_en;
    logic        chan_init;
    t_chan_state rd_state;
    t_chan_state wr_state;
    logic        emit;
    t_event      event_d;

    assign in_sample.channel  = i_s_axis_tdata[5:0];
    assign in_sample.raw_down = i_s_axis_tdata[6];
    assign in_sample.time_ms  = i_s_axis_tdata[38:7];

    assign s1_fire         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_fire;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign s1_in_range     = {{(CHAN_CNT_W-CHAN_W){1'b0}}, r_s1.channel}
                             < CHAN_CNT_W'(NUM_CHANNELS);
    assign wr_en           = s1_fire && s1_in_range;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deb_ms    <= DEBOUNCE_RST;
            r_cfg.held_ms   <= HELD_RST;
            r_cfg.kind_mask <= MASK_RST;
            r_cfg.source    <= SOURCE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_cfg.deb_ms    <= i_cfg_data;
                CFG_HELD:     r_cfg.held_ms   <= i_cfg_data;
                CFG_MASK:     r_cfg.kind_mask <= i_cfg_data[2:0];
                CFG_SOURCE:   r_cfg.source    <= i_cfg_data[2:0];
                default:      r_cfg.source    <= r_cfg.source;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1 <= in_sample;
        end
    end

    kdhe_chan_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AW           (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (s_accept),
        .i_rd_addr (AW'(in_sample.channel)),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_s1.channel)),
        .i_wr_data (wr_state),
        .o_rd_data (rd_state),
        .o_init    (chan_init)
    );

    kdhe_update u_update (
        .i_sample   (r_s1),
        .i_in_range (s1_in_range),
        .i_init     (chan_init),
        .i_state    (rd_state),
        .i_cfg      (r_cfg),
        .o_state    (wr_state),
        .o_emit     (emit),
        .o_event    (event_d)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid <= emit;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out <= event_d;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tdata  = {7'd0, r_out.source, r_out.duration, r_out.time_ms,
                              r_out.channel};

`include "assert_macros.svh"

    `KDHE_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_m_axis_tvalid, "event after reset")
    `KDHE_ASSERT(a_kind_legal, o_m_axis_tvalid |-> (o_m_axis_tuser == KIND_DOWN || o_m_axis_tuser == KIND_UP || o_m_axis_tuser == KIND_HELD), "bad event kind")
    `KDHE_ASSERT(a_down_zero, (o_m_axis_tvalid && o_m_axis_tuser == KIND_DOWN) |-> (r_out.duration == '0), "down event with duration")
    `KDHE_ASSERT(a_event_src, $rose(o_m_axis_tvalid) |-> $past(r_s1_valid), "event without sample")

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kdhe_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;
    logic [1:0]            o_m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    key_debounce_held_events_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow registers
    bit [15:0] cfg_debounce = DEBOUNCE_RST;
    bit [15:0] cfg_held     = HELD_RST;
    bit [2:0]  cfg_mask     = MASK_RST;
    bit [2:0]  cfg_source   = SOURCE_RST;

    // per-channel debounce state
    bit        cs_seen     [64];
    bit        cs_stable   [64];
    bit        cs_raw      [64];
    bit [31:0] cs_change_t [64];
    bit [31:0] cs_press_t  [64];
    bit [31:0] cs_held_due [64];

    t_event pending_events [$];
    int     errors = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    int     rx_hold_seq = 0;
    int     rx_hold_seen = 0;
    int     hold_left = 0;
    int     quiet_cycles = 0;

    function automatic t_event make_event(input logic [1:0] kind, input bit [5:0] ch,
                                          input bit [31:0] now, input bit [31:0] dur);
        t_event ev;
        ev.kind     = kind;
        ev.channel  = ch;
        ev.time_ms  = now;
        ev.duration = dur;
        ev.source   = cfg_source;
        return ev;
    endfunction

    // updates channel state; returns 1 when an unmasked event comes out
    function automatic bit debounce_predict(input bit [5:0] ch, input bit raw,
                                            input bit [31:0] now, output t_event ev);
        bit [31:0] since_due;
        ev = '0;
        if (!cs_seen[ch]) begin
            cs_seen[ch]     = 1'b1;
            cs_stable[ch]   = raw;
            cs_raw[ch]      = raw;
            cs_change_t[ch] = now;
            if (raw) begin
                cs_press_t[ch]  = now;
                cs_held_due[ch] = now + cfg_held;
            end
            return 1'b0;
        end
        if (cs_raw[ch] != raw) begin
            cs_raw[ch]      = raw;
            cs_change_t[ch] = now;
            return 1'b0;
        end
        if (cs_stable[ch] != raw) begin
            if (now - cs_change_t[ch] < 32'(cfg_debounce))
                return 1'b0;
            cs_stable[ch] = raw;
            if (raw) begin
                cs_press_t[ch]  = now;
                cs_held_due[ch] = now + cfg_held;
                ev = make_event(KIND_DOWN, ch, now, 32'd0);
                return cfg_mask[KIND_DOWN];
            end
            ev = make_event(KIND_UP, ch, now, now - cs_press_t[ch]);
            return cfg_mask[KIND_UP];
        end
        since_due = now - cs_held_due[ch];
        if (cs_stable[ch] && cfg_held != 16'd0 && !since_due[31]) begin
            cs_held_due[ch] = now + cfg_held;
            ev = make_event(KIND_HELD, ch, now, now - cs_press_t[ch]);
            return cfg_mask[KIND_HELD];
        end
        return 1'b0;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_events
        t_event want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_events.size() == 0) begin
                $error("event with none expected: kind %0d channel %0d",
                       o_m_axis_tuser, o_m_axis_tdata[5:0]);
                errors++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", 32'(want.kind), 32'(o_m_axis_tuser));
                check_field("event_chan", 32'(want.channel), 32'(o_m_axis_tdata[5:0]));
                check_field("event_time_ms", want.time_ms, o_m_axis_tdata[37:6]);
                check_field("press_duration_ms", want.duration, o_m_axis_tdata[69:38]);
                check_field("event_source", 32'(want.source), 32'(o_m_axis_tdata[72:70]));
            end
        end
    end

    // output side ready, with an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_axis_tready = 1'b0;
            hold_left--;
        end else if (rx_hold_seen != rx_hold_seq) begin
            rx_hold_seen = rx_hold_seq;
            hold_left = HOLD_CYCLES - 1;
            i_m_axis_tready = 1'b0;
        end else begin
            i_m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_sample(input bit [5:0] ch, input bit raw, input bit [31:0] now);
        t_event ev;
        while ($urandom_range(0, 99) < tx_idle_pct) @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {1'b0, now, raw, ch};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (debounce_predict(ch, raw, now, ev))
            pending_events.push_back(ev);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DEBOUNCE: cfg_debounce = data;
            CFG_HELD:     cfg_held = data;
            CFG_MASK:     cfg_mask = data[2:0];
            CFG_SOURCE:   cfg_source = data[2:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // upper bits of the 3-bit registers carry noise
    task automatic set_registers(input bit [15:0] deb, input bit [15:0] held,
                                 input bit [2:0] mask, input bit [2:0] src);
        wait_drained();
        cfg_write(CFG_DEBOUNCE, deb);
        cfg_write(CFG_HELD, held);
        cfg_write(CFG_MASK, {13'($urandom), mask});
        cfg_write(CFG_SOURCE, {13'($urandom), src});
    endtask

    task automatic set_idle(input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
    endtask

    task automatic test_reset_defaults();
        set_idle(27, 65);
        send_sample(6'd0, 1'b0, 32'd100);
        send_sample(6'd0, 1'b1, 32'd110);
        send_sample(6'd0, 1'b1, 32'd129);
        send_sample(6'd0, 1'b1, 32'd130);
        send_sample(6'd0, 1'b1, 32'd5000);
        send_sample(6'd0, 1'b0, 32'd5001);
        send_sample(6'd0, 1'b0, 32'd5021);
        // press across the timestamp wrap
        send_sample(6'd63, 1'b1, 32'hFFFF_FFF0);
        send_sample(6'd63, 1'b0, 32'hFFFF_FFF8);
        send_sample(6'd63, 1'b0, 32'h0000_000C);
        set_idle(0, 0);
        send_sample(6'd42, 1'b0, 32'h2A);
        send_sample(6'd42, 1'b1, 32'h2B);
        send_sample(6'd42, 1'b1, 32'h3F);
    endtask

    task automatic test_register_extremes();
        set_idle(27, 65);
        set_registers(16'd0, 16'd1, 3'd7, 3'd7);
        send_sample(6'd1, 1'b0, 32'd0);
        send_sample(6'd1, 1'b1, 32'd0);
        send_sample(6'd1, 1'b1, 32'd0);
        send_sample(6'd1, 1'b1, 32'd1);
        send_sample(6'd1, 1'b1, 32'h8000_0001);
        send_sample(6'd1, 1'b1, 32'h0000_0002);
        // all kinds masked
        set_registers(16'd0, 16'hFFFF, 3'd0, 3'd7);
        send_sample(6'd1, 1'b0, 32'd10);
        send_sample(6'd1, 1'b0, 32'd10);
        send_sample(6'd2, 1'b1, 32'd7);
        // deadline keeps the period in force at press time
        set_registers(16'd0, 16'd1, 3'd7, 3'd0);
        send_sample(6'd2, 1'b1, 32'd8);
        send_sample(6'd2, 1'b1, 32'd65542);
        send_sample(6'd2, 1'b1, 32'd65543);
    endtask

    task automatic test_backpressure();
        bit [31:0] t0;
        t0 = $urandom;
        set_idle(0, 0);
        set_registers(16'd0, 16'd1, 3'd7, 3'd5);
        send_sample(6'd9, 1'b1, t0);
        rx_hold_seq++;
        for (int k = 1; k <= 30; k++)
            send_sample(6'd9, 1'b1, t0 + k);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        bit [31:0] stim_t [64];
        bit        stim_level [64];
        bit [5:0]  ch;
        bit        raw;
        bit [31:0] span;
        int        r;
        foreach (stim_t[c]) begin
            stim_t[c]     = $urandom;
            stim_level[c] = 1'($urandom);
        end
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin set_idle(27, 65); set_registers(16'd20, 16'd50, 3'd7, 3'd3); end
                1: begin set_idle(27, 65); set_registers(16'd0, 16'd0, 3'd7, 3'd7); end
                2: begin
                    set_idle(65, 27);
                    set_registers(16'hFFFF, 16'hFFFF, 3'd7, 3'd0);
                end
                3: begin
                    set_idle(65, 27);
                    set_registers(16'($urandom_range(0, 100)), 16'($urandom_range(1, 100)),
                                  3'($urandom), 3'($urandom));
                end
                4: begin set_idle(0, 0); set_registers(16'd5, 16'd1, 3'd5, 3'd6); end
                default: begin
                    set_idle(0, 0);
                    set_registers(16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                                  3'd7, 3'($urandom));
                end
            endcase
            for (int n = 0; n < 200; n++) begin
                ch = ($urandom_range(0, 99) < 75) ? 6'($urandom_range(0, 7))
                                                  : 6'($urandom_range(0, 63));
                r = $urandom_range(0, 99);
                span = ($urandom_range(0, 1) ? 32'(cfg_debounce) : 32'(cfg_held)) * 2 + 3;
                if (r < 4)
                    stim_t[ch] = $urandom;
                else if (r >= 8)
                    stim_t[ch] = stim_t[ch] + $urandom_range(0, span);
                if ($urandom_range(0, 99) < 10)
                    stim_level[ch] = ~stim_level[ch];
                // occasional contact bounce
                raw = stim_level[ch] ^ ($urandom_range(0, 99) < 8);
                send_sample(ch, raw, stim_t[ch]);
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_defaults();
        test_register_extremes();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_events.size() != 0) begin
            $error("%0d expected events never arrived", pending_events.size());
            errors++;
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
